FILE: src/b64_pkg.sv
package b64_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = 1;
    localparam int unsigned QueueCntW  = 2;

    localparam logic [7:0] PadChar   = 8'h3D;
    localparam logic [1:0] LastSlice = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_last;
    } out_t;

    // One closed group: 24 data bits, number of bytes held before the
    // closing byte (0..2), and whether it ends the message.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  have;
        logic        fin;
    } group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

FILE: src/b64_front.sv
module b64_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  b64_pkg::in_t    in_item,
    output logic            grp_valid,
    input  logic            grp_ready,
    output b64_pkg::group_t grp
);
    import b64_pkg::*;

    logic [1:0] count_reg, count_next;
    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic       close_grp;
    logic       take;

    // Stall on any byte while the queue is full, so ready does not
    // depend on the payload.
    assign in_ready  = grp_ready;
    assign take      = in_valid && in_ready;
    assign close_grp = in_item.final_byte || (count_reg == 2'd2);
    assign grp_valid = in_valid && close_grp;

    always_comb
    begin
        grp.have = count_reg;
        grp.fin  = in_item.final_byte;
        case (count_reg)
            2'd0:    grp.bits = {in_item.data_byte, 16'h0000};
            2'd1:    grp.bits = {pend0_reg, in_item.data_byte, 8'h00};
            default: grp.bits = {pend0_reg, pend1_reg, in_item.data_byte};
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        if (take)
        begin
            if (close_grp)
            begin
                count_next = 2'd0;
            end
            else
            begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                begin
                    pend0_next = in_item.data_byte;
                end
                else
                begin
                    pend1_next = in_item.data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

FILE: src/b64_queue.sv
module b64_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  b64_pkg::group_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output b64_pkg::group_t rd_data
);
    import b64_pkg::*;

    group_t                 slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]   cnt_reg, cnt_next;
    logic                   push;
    logic                   pop;

    assign wr_ready = (cnt_reg != QueueCntW'(QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QueuePtrW'(push);
        rd_ptr_next = rd_ptr_reg + QueuePtrW'(pop);
        cnt_next    = cnt_reg + QueueCntW'(push) - QueueCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/b64_back.sv
module b64_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            grp_valid,
    output logic            grp_ready,
    input  b64_pkg::group_t grp,
    output logic            out_valid,
    input  logic            out_ready,
    output b64_pkg::out_t   out_item
);
    import b64_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    group_t     cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;
    logic       advance;
    logic       load;
    logic [5:0] slice;
    logic       pad;
    out_t       ch;

    assign advance   = cur_valid_reg && (!out_valid_reg || out_ready);
    assign load      = grp_valid && (!cur_valid_reg || (advance && idx_reg == LastSlice));
    assign grp_ready = !cur_valid_reg || (advance && idx_reg == LastSlice);

    always_comb
    begin
        case (idx_reg)
            2'd0:    slice = cur_reg.bits[23:18];
            2'd1:    slice = cur_reg.bits[17:12];
            2'd2:    slice = cur_reg.bits[11:6];
            default: slice = cur_reg.bits[5:0];
        endcase
        // have + 1 real bytes fill have + 2 characters; pad the rest
        pad             = ({1'b0, idx_reg} > ({1'b0, cur_reg.have} + 3'd1));
        ch.out_char     = pad ? PadChar : b64_char(slice);
        ch.run_last     = (idx_reg == LastSlice);
        ch.message_last = cur_reg.fin && (idx_reg == LastSlice);
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = ch;
            idx_next       = idx_reg + 2'd1;
            if (idx_reg == LastSlice)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_next       = grp;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: src/base64_encoder.sv
// Streaming base64 encoder (standard alphabet, '=' padding). One message
// byte is taken per transfer; a byte that completes three, or carries
// final_byte, closes a group that yields four characters, one per cycle
// while out_ready is held, with run_last on the fourth and message_last
// also set on the fourth of a message's last group. Bytes are taken every
// cycle while the two-entry group queue has room; the character output
// register sets the rate at one character per cycle while out_ready is
// held. A group's first character passes through the queue slot, the
// current-group register and the character output register before it appears.
module base64_encoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  b64_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output b64_pkg::out_t out_item
);
    import b64_pkg::*;

    logic   fq_valid;
    logic   fq_ready;
    group_t fq_data;
    logic   qb_valid;
    logic   qb_ready;
    group_t qb_data;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .grp_valid (fq_valid),
        .grp_ready (fq_ready),
        .grp       (fq_data)
    );

    b64_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (qb_valid),
        .grp_ready (qb_ready),
        .grp       (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: sim/tb_base64_encoder.sv
`timescale 1ns / 100ps

module tb_base64_encoder;

    import b64_pkg::*;

    localparam int RandomBytes   = 470;
    localparam int QuietTail     = 50;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 16;

    localparam logic [511:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_item;
    logic out_valid;
    logic out_ready;
    out_t out_item;

    in_t  byte_stream [$];
    out_t chars_due [$];

    logic [7:0] held_bytes [2];
    int         held_count;

    int n_items;
    int quiet_from;
    int bytes_sent;
    int mismatches;
    int idle_left;
    int stall_left;
    int stuck_cycles;
    bit timed_out;

    base64_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
        return Alphabet[8 * (63 - int'(idx)) +: 8];
    endfunction

    // Update the group state for one transferred byte and queue the
    // characters it closes.
    function automatic void encode_byte(input in_t item);
        logic [23:0] grp;
        out_t        res;
        if (!item.final_byte && held_count < 2)
        begin
            held_bytes[held_count] = item.data_byte;
            held_count++;
            return;
        end
        case (held_count)
            0:       grp = {item.data_byte, 16'h0000};
            1:       grp = {held_bytes[0], item.data_byte, 8'h00};
            default: grp = {held_bytes[0], held_bytes[1], item.data_byte};
        endcase
        for (int k = 0; k < 4; k++)
        begin
            if (k >= held_count + 2)
            begin
                res.out_char = PadChar;
            end
            else
            begin
                res.out_char = alphabet_char(grp[18 - 6 * k +: 6]);
            end
            res.run_last     = (k == 3);
            res.message_last = (k == 3) && item.final_byte;
            chars_due.insert(chars_due.size(), res);
        end
        held_count = 0;
    endfunction

    // Queue a message of len bytes taken from the top of msg.
    task automatic add_message(input logic [63:0] msg, input int len);
        in_t item;
        for (int i = 0; i < len; i++)
        begin
            item.data_byte  = msg[63 - 8 * i -: 8];
            item.final_byte = (i == len - 1);
            byte_stream.insert(byte_stream.size(), item);
        end
    endtask

    // Driver: hold the payload until transfer, idle in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            idle_left  <= 0;
            bytes_sent <= 0;
            held_count  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encode_byte(in_item);
                bytes_sent <= bytes_sent + 1;
            end
            if (in_valid && !in_ready)
            begin
                in_valid <= 1'b1;
            end
            else if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                in_valid  <= 1'b0;
            end
            else if (byte_stream.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (bytes_sent < quiet_from && $urandom_range(0, 9) == 0)
            begin
                idle_left <= $urandom_range(0, 17);
                in_valid  <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                in_item  <= byte_stream.pop_front();
            end
        end
    end

    // Monitor: compare each character transfer with the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (chars_due.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %h/%b/%b",
                             $time, out_item.out_char, out_item.run_last,
                             out_item.message_last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    if (out_item.out_char !== chars_due[0].out_char ||
                        out_item.run_last !== chars_due[0].run_last ||
                        out_item.message_last !== chars_due[0].message_last)
                    begin
                        $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                                 $time, chars_due[0].out_char, chars_due[0].run_last,
                                 chars_due[0].message_last, out_item.out_char,
                                 out_item.run_last, out_item.message_last);
                        mismatches <= mismatches + 1;
                    end
                    void'(chars_due.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (bytes_sent < quiet_from && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 17);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        int   len;
        logic [63:0] msg;
        rst_n      = 1'b0;
        timed_out  = 1'b0;
        quiet_from = 0;

        // Short messages: one, two and three leftover bytes, slices 0, 62, 63.
        add_message(64'h00 << 56, 1);
        add_message(64'hFF << 56, 1);
        add_message(64'h0000 << 48, 2);
        add_message(64'hFFFF << 48, 2);
        add_message(64'hFFFFFF << 40, 3);
        add_message(64'hFBEFBE00 << 32, 4);
        add_message(64'h00108310_51 << 24, 5);
        add_message(64'hD75DB7E3_9EFB << 16, 6);

        while (byte_stream.size() < 24 + RandomBytes)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
            for (int i = 0; i < 8; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       msg[8 * i +: 8] = 8'h00;
                    1:       msg[8 * i +: 8] = 8'hFF;
                    default: msg[8 * i +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
            add_message(msg, len);
        end
        n_items    = byte_stream.size();
        quiet_from = n_items - QuietTail;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (!(bytes_sent == n_items && chars_due.size() == 0))
                begin
                    @(posedge clk);
                end
                repeat (DrainCycles) @(posedge clk);
            end
            begin
                while (stuck_cycles < WatchdogLimit)
                begin
                    @(posedge clk);
                end
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (!timed_out && mismatches == 0 && chars_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: base64_encoder.f
src/b64_pkg.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_encoder.sv
sim/tb_base64_encoder.sv
